FILE: rtl/core/iasw_pkg.sv
// Shared types, codes and helpers for the sub-cube address walker
package iasw_pkg;

    // Fixed field widths
    localparam int FIELD_W    = 16;
    localparam int ADDR_W     = 56;
    localparam int ELEM_W     = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int HDR_W      = 32;

    // Queue between front and back (power of two, pointers wrap naturally)
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Storage orders
    localparam logic [1:0] MODE_BSQ = 2'd0;
    localparam logic [1:0] MODE_BIL = 2'd1;
    localparam logic [1:0] MODE_BIP = 2'd2;

    // Commands
    localparam logic CMD_RESTART = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    // Result status
    localparam logic [1:0] ST_VALID      = 2'd0;
    localparam logic [1:0] ST_BAD_WINDOW = 2'd1;
    localparam logic [1:0] ST_IDLE       = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ETYPE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SWAP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIMS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_BEG  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_END  = 3'd6;

    // Element types
    localparam logic [3:0] ET_BYTE   = 4'd0;
    localparam logic [3:0] ET_INT16  = 4'd1;
    localparam logic [3:0] ET_INT32  = 4'd2;
    localparam logic [3:0] ET_FLOAT  = 4'd3;
    localparam logic [3:0] ET_DOUBLE = 4'd4;
    localparam logic [3:0] ET_UINT16 = 4'd5;
    localparam logic [3:0] ET_UINT32 = 4'd6;
    localparam logic [3:0] ET_UINT64 = 4'd7;
    localparam logic [3:0] ET_ULONG  = 4'd8;

    // Configuration as seen by front and back
    typedef struct packed {
        logic [1:0]            mode;
        logic [3:0]            etype;
        logic                  swap;
        logic [HDR_W-1:0]      header;
        logic [CFG_DATA_W-1:0] dims;
        logic [CFG_DATA_W-1:0] win_beg;
        logic [CFG_DATA_W-1:0] win_end;
    } cfg_t;

    // Classified request handed from front to back
    typedef struct packed {
        logic [1:0]         status;
        logic               last;
        logic [FIELD_W-1:0] outer;
        logic [FIELD_W-1:0] middle;
        logic [FIELD_W-1:0] inner;
        logic [ELEM_W-1:0]  raw;
    } walk_rec_t;

    // Element size in bytes, unknown types take 4, limited to max_bytes
    function automatic logic [3:0] elem_bytes(input logic [3:0] etype, input int max_bytes);
        logic [3:0] n;
        logic [3:0] lim;
        begin
            lim = 4'(max_bytes);
            case (etype)
                ET_BYTE:                       n = 4'd1;
                ET_INT16, ET_UINT16:           n = 4'd2;
                ET_DOUBLE, ET_UINT64, ET_ULONG: n = 4'd8;
                default:                       n = 4'd4;
            endcase
            if (n > lim)
            begin
                n = lim;
            end
            if (n == 4'd0)
            begin
                n = 4'd1;
            end
            return n;
        end
    endfunction

endpackage

FILE: rtl/core/interleaved_subcube_address_walker_unit.sv
// Channel   | Handshake              | Payload
// ----------+------------------------+---------------------------------------------
// config    | cfg_wr_en              | cfg_index, cfg_data
// request   | in_valid / in_ready    | command, raw_element
// result    | out_valid / out_ready  | byte_address, row_pos, col_pos, band_pos,
//           |                        | ordered_element, last, status
//
// The front takes one request per cycle while the two-entry queue has room.
// The back takes each request through pop, two multiply steps and finish, and
// pops the next request only after the finish has loaded the output register,
// which waits while a stalled result is still held there.
// Reset clears the walk, queue and output valid, and loads the register defaults.
// A stalled result sits in the output register while the front keeps filling the queue.
module interleaved_subcube_address_walker_unit
    import iasw_pkg::*;
#(
    parameter int DIM_BITS          = 16,
    parameter int MAX_ELEMENT_BYTES = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  command,
    input  logic [ELEM_W-1:0]     raw_element,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [ADDR_W-1:0]     byte_address,
    output logic [FIELD_W-1:0]    row_pos,
    output logic [FIELD_W-1:0]    col_pos,
    output logic [FIELD_W-1:0]    band_pos,
    output logic [ELEM_W-1:0]     ordered_element,
    output logic                  last,
    output logic [1:0]            status
);

    logic [1:0]            mode_reg;
    logic [3:0]            etype_reg;
    logic                  swap_reg;
    logic [HDR_W-1:0]      header_reg;
    logic [CFG_DATA_W-1:0] dims_reg;
    logic [CFG_DATA_W-1:0] win_beg_reg;
    logic [CFG_DATA_W-1:0] win_end_reg;

    cfg_t      cfg;
    walk_rec_t front_rec;
    walk_rec_t head_rec;
    logic      push, pop, q_full, q_empty;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_BSQ;
            etype_reg   <= ET_FLOAT;
            swap_reg    <= 1'b0;
            header_reg  <= '0;
            dims_reg    <= '0;
            win_beg_reg <= '0;
            win_end_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_MODE:    mode_reg    <= cfg_data[1:0];
                REG_ETYPE:   etype_reg   <= cfg_data[3:0];
                REG_SWAP:    swap_reg    <= cfg_data[0];
                REG_HEADER:  header_reg  <= cfg_data[HDR_W-1:0];
                REG_DIMS:    dims_reg    <= cfg_data;
                REG_WIN_BEG: win_beg_reg <= cfg_data;
                REG_WIN_END: win_end_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        cfg.mode    = mode_reg;
        cfg.etype   = etype_reg;
        cfg.swap    = swap_reg;
        cfg.header  = header_reg;
        cfg.dims    = dims_reg;
        cfg.win_beg = win_beg_reg;
        cfg.win_end = win_end_reg;
    end

    iasw_front #(
        .DIM_BITS (DIM_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .raw_element (raw_element),
        .q_full      (q_full),
        .push        (push),
        .rec         (front_rec)
    );

    iasw_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (front_rec),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .head     (head_rec)
    );

    iasw_back #(
        .DIM_BITS          (DIM_BITS),
        .MAX_ELEMENT_BYTES (MAX_ELEMENT_BYTES)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .q_empty         (q_empty),
        .pop             (pop),
        .q_rec           (head_rec),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .byte_address    (byte_address),
        .row_pos         (row_pos),
        .col_pos         (col_pos),
        .band_pos        (band_pos),
        .ordered_element (ordered_element),
        .last            (last),
        .status          (status)
    );

endmodule

FILE: rtl/core/iasw_front.sv
// Front: takes requests, steps the walk counters, classifies the result
module iasw_front
    import iasw_pkg::*;
#(
    parameter int DIM_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              command,
    input  logic [ELEM_W-1:0] raw_element,
    input  logic              q_full,
    output logic              push,
    output walk_rec_t         rec
);

    localparam int CW = (DIM_BITS < FIELD_W) ? DIM_BITS : FIELD_W;

    logic [CW-1:0] outer_reg, outer_next;
    logic [CW-1:0] middle_reg, middle_next;
    logic [CW-1:0] inner_reg, inner_next;
    logic          active_reg, active_next;

    logic [CW-1:0] b_row, b_col, b_band, e_row, e_col, e_band, d_row, d_col, d_band;
    logic [CW-1:0] b_o, b_m, b_i, e_o, e_m, e_i;
    logic          bad_window;
    logic [CW:0]   inc_o, inc_m, inc_i;
    logic [CW:0]   nxt_o1, nxt_m1, nxt_i1;
    logic          last_c;
    logic [1:0]    status_c;

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

    // Unpacked window and cube fields, masked to the coordinate width
    assign b_row  = cfg.win_beg[0 +: CW];
    assign b_col  = cfg.win_beg[FIELD_W +: CW];
    assign b_band = cfg.win_beg[2*FIELD_W +: CW];
    assign e_row  = cfg.win_end[0 +: CW];
    assign e_col  = cfg.win_end[FIELD_W +: CW];
    assign e_band = cfg.win_end[2*FIELD_W +: CW];
    assign d_row  = cfg.dims[0 +: CW];
    assign d_col  = cfg.dims[FIELD_W +: CW];
    assign d_band = cfg.dims[2*FIELD_W +: CW];

    // Axis order of outer, middle and inner counter
    always_comb
    begin
        case (cfg.mode)
            MODE_BIL:
            begin
                b_o = b_row;  b_m = b_band; b_i = b_col;
                e_o = e_row;  e_m = e_band; e_i = e_col;
            end
            MODE_BIP:
            begin
                b_o = b_row;  b_m = b_col;  b_i = b_band;
                e_o = e_row;  e_m = e_col;  e_i = e_band;
            end
            default:
            begin
                b_o = b_band; b_m = b_row;  b_i = b_col;
                e_o = e_band; e_m = e_row;  e_i = e_col;
            end
        endcase
    end

    assign bad_window = (b_row >= e_row) || (e_row > d_row)
                     || (b_col >= e_col) || (e_col > d_col)
                     || (b_band >= e_band) || (e_band > d_band);

    assign inc_o = {1'b0, outer_reg} + 1'b1;
    assign inc_m = {1'b0, middle_reg} + 1'b1;
    assign inc_i = {1'b0, inner_reg} + 1'b1;

    // Counter step with carry from inner to outer
    always_comb
    begin
        outer_next  = outer_reg;
        middle_next = middle_reg;
        inner_next  = inner_reg;
        status_c    = ST_VALID;
        if (command == CMD_RESTART)
        begin
            if (bad_window)
            begin
                status_c = ST_BAD_WINDOW;
            end
            else
            begin
                outer_next  = b_o;
                middle_next = b_m;
                inner_next  = b_i;
            end
        end
        else if (!active_reg)
        begin
            status_c = ST_IDLE;
        end
        else if (inc_i < {1'b0, e_i})
        begin
            inner_next = inc_i[CW-1:0];
        end
        else
        begin
            inner_next = b_i;
            if (inc_m < {1'b0, e_m})
            begin
                middle_next = inc_m[CW-1:0];
            end
            else
            begin
                middle_next = b_m;
                if (inc_o < {1'b0, e_o})
                begin
                    outer_next = inc_o[CW-1:0];
                end
                else
                begin
                    // carry out of the outer counter ends the walk
                    outer_next = b_o;
                    status_c   = ST_IDLE;
                end
            end
        end
    end

    // Final element test on the stepped counters
    assign nxt_o1 = {1'b0, outer_next} + 1'b1;
    assign nxt_m1 = {1'b0, middle_next} + 1'b1;
    assign nxt_i1 = {1'b0, inner_next} + 1'b1;
    assign last_c = (nxt_i1 >= {1'b0, e_i}) && (nxt_m1 >= {1'b0, e_m})
                 && (nxt_o1 >= {1'b0, e_o});

    always_comb
    begin
        active_next = active_reg;
        if (status_c == ST_VALID)
        begin
            active_next = !last_c;
        end
        else if (status_c == ST_BAD_WINDOW || (command == CMD_ADVANCE && active_reg))
        begin
            active_next = 1'b0;
        end
    end

    always_comb
    begin
        rec.status = status_c;
        rec.last   = (status_c == ST_VALID) && last_c;
        rec.outer  = FIELD_W'(outer_next);
        rec.middle = FIELD_W'(middle_next);
        rec.inner  = FIELD_W'(inner_next);
        rec.raw    = raw_element;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outer_reg  <= '0;
            middle_reg <= '0;
            inner_reg  <= '0;
            active_reg <= 1'b0;
        end
        else if (push)
        begin
            outer_reg  <= outer_next;
            middle_reg <= middle_next;
            inner_reg  <= inner_next;
            active_reg <= active_next;
        end
    end

endmodule

FILE: rtl/core/iasw_queue.sv
// Short register queue between front and back
module iasw_queue
    import iasw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  walk_rec_t push_rec,
    output logic      full,
    input  logic      pop,
    output logic      empty,
    output walk_rec_t head
);

    walk_rec_t               mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]  count_reg, count_next;

    assign full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

FILE: rtl/core/iasw_back.sv
// Back: linear index over two multiply steps, byte address, byte order
module iasw_back
    import iasw_pkg::*;
#(
    parameter int DIM_BITS          = 16,
    parameter int MAX_ELEMENT_BYTES = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               q_empty,
    output logic               pop,
    input  walk_rec_t          q_rec,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [ADDR_W-1:0]  byte_address,
    output logic [FIELD_W-1:0] row_pos,
    output logic [FIELD_W-1:0] col_pos,
    output logic [FIELD_W-1:0] band_pos,
    output logic [ELEM_W-1:0]  ordered_element,
    output logic               last,
    output logic [1:0]         status
);

    localparam int CW   = (DIM_BITS < FIELD_W) ? DIM_BITS : FIELD_W;
    localparam int P1_W = 2 * CW + 1;
    localparam int P2_W = 3 * CW + 2;
    localparam int P3_W = P2_W + 4;

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_MUL1 = 2'd1;
    localparam logic [1:0] B_MUL2 = 2'd2;
    localparam logic [1:0] B_FIN  = 2'd3;

    logic [1:0]         state_reg, state_next;
    walk_rec_t          rec_reg;
    logic [P1_W-1:0]    prod1_reg;
    logic [P2_W-1:0]    prod2_reg;

    logic               out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]  addr_reg;
    logic [FIELD_W-1:0] row_reg, col_reg, band_reg;
    logic [ELEM_W-1:0]  ord_reg;
    logic               last_reg;
    logic [1:0]         status_reg;

    logic [CW-1:0]      o_c, m_c, i_c, d_m, d_i;
    logic [CW-1:0]      row_c, col_c, band_c;
    logic [P1_W-1:0]    mult1;
    logic [P2_W-1:0]    mult2;
    logic [3:0]         n_bytes;
    logic [P3_W-1:0]    scaled;
    logic [ADDR_W-1:0]  addr_c;
    logic [ELEM_W-1:0]  ord_c;
    logic               fin_load;
    logic               ok;

    assign o_c = rec_reg.outer[CW-1:0];
    assign m_c = rec_reg.middle[CW-1:0];
    assign i_c = rec_reg.inner[CW-1:0];

    // Mode selects dimension sizes and coordinate placement
    always_comb
    begin
        case (cfg.mode)
            MODE_BIL:
            begin
                d_m = cfg.dims[2*FIELD_W +: CW];
                d_i = cfg.dims[FIELD_W +: CW];
                row_c = o_c; band_c = m_c; col_c = i_c;
            end
            MODE_BIP:
            begin
                d_m = cfg.dims[FIELD_W +: CW];
                d_i = cfg.dims[2*FIELD_W +: CW];
                row_c = o_c; col_c = m_c; band_c = i_c;
            end
            default:
            begin
                d_m = cfg.dims[0 +: CW];
                d_i = cfg.dims[FIELD_W +: CW];
                band_c = o_c; row_c = m_c; col_c = i_c;
            end
        endcase
    end

    // Linear index: (outer * d_m + middle) * d_i + inner
    assign mult1 = P1_W'(o_c) * P1_W'(d_m) + P1_W'(m_c);
    assign mult2 = P2_W'(prod1_reg) * P2_W'(d_i) + P2_W'(i_c);

    // Byte address
    assign n_bytes = elem_bytes(cfg.etype, MAX_ELEMENT_BYTES);
    assign scaled  = P3_W'(prod2_reg) * P3_W'(n_bytes);
    assign addr_c  = ADDR_W'(cfg.header) + ADDR_W'(scaled);

    // Element bytes, reversed within the element size when swapping
    always_comb
    begin
        logic [3:0] dst;
        ord_c = '0;
        for (int b = 0; b < ELEM_W / 8; b++)
        begin
            dst = cfg.swap ? (n_bytes - 4'd1 - 4'(b)) : 4'(b);
            if (4'(b) < n_bytes)
            begin
                ord_c[dst[2:0]*8 +: 8] = rec_reg.raw[b*8 +: 8];
            end
        end
    end

    assign pop      = (state_reg == B_IDLE) && !q_empty;
    assign fin_load = (state_reg == B_FIN) && (!out_valid_reg || out_ready);
    assign ok       = (rec_reg.status == ST_VALID);

    // Sequencer: pop, two multiply steps, finish into output register
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = B_MUL1;
                end
            end
            B_MUL1:  state_next = B_MUL2;
            B_MUL2:  state_next = B_FIN;
            B_FIN:
            begin
                if (fin_load)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fin_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rec_reg <= q_rec;
        end
        if (state_reg == B_MUL1)
        begin
            prod1_reg <= mult1;
        end
        if (state_reg == B_MUL2)
        begin
            prod2_reg <= mult2;
        end
        if (fin_load)
        begin
            addr_reg   <= ok ? addr_c : '0;
            row_reg    <= ok ? FIELD_W'(row_c) : '0;
            col_reg    <= ok ? FIELD_W'(col_c) : '0;
            band_reg   <= ok ? FIELD_W'(band_c) : '0;
            ord_reg    <= ok ? ord_c : '0;
            last_reg   <= ok && rec_reg.last;
            status_reg <= rec_reg.status;
        end
    end

    assign out_valid       = out_valid_reg;
    assign byte_address    = addr_reg;
    assign row_pos         = row_reg;
    assign col_pos         = col_reg;
    assign band_pos        = band_reg;
    assign ordered_element = ord_reg;
    assign last            = last_reg;
    assign status          = status_reg;

endmodule
